// ===== rtl/rddg_pkg.sv =====
// shared types and constants of the repeating decimal digit generator
// no dependencies; used by the interfaces, the top level and the checker
package rddg_pkg;

  localparam int NUM_W    = 16;  // numerator and quotient width
  localparam int DIV_W    = 10;  // divisor and remainder width
  localparam int POS_W    = 10;  // digit position width
  localparam int DIGIT_W  = 16;
  localparam int EPOCH_W  = 6;   // generation tag kept with every table entry
  localparam int TBL_DEPTH = 1024;
  localparam int TBL_AW   = 10;
  localparam int STEP_W   = $clog2(NUM_W);
  localparam int DVD_W    = 14;  // width of ten times a remainder

  localparam logic [STEP_W-1:0]  STEP_LAST   = STEP_W'(NUM_W - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  typedef enum logic [1:0] {
    STAT_MORE   = 2'd0,
    STAT_EXACT  = 2'd1,
    STAT_REPEAT = 2'd2,
    STAT_ERROR  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_NEXT,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [POS_W-1:0]   pos;
  } tbl_entry_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    status_e            status;
    logic [POS_W-1:0]   cycle_start;
    logic [POS_W-1:0]   cycle_length;
  } res_t;

endpackage

// ===== rtl/rddg_req_if.sv =====
// request channel: operation code and division operands
// depends on rddg_pkg
interface rddg_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [rddg_pkg::NUM_W-1:0]  numerator;
  logic [rddg_pkg::DIV_W-1:0]  divisor;

  modport source (output valid, func, numerator, divisor, input ready);
  modport sink   (input valid, func, numerator, divisor, output ready);
endinterface

// ===== rtl/rddg_res_if.sv =====
// result channel: one digit with its position and status
// depends on rddg_pkg
interface rddg_res_if;
  logic                          valid;
  logic                          ready;
  logic [rddg_pkg::DIGIT_W-1:0]  digit;
  logic [rddg_pkg::POS_W-1:0]    position;
  rddg_pkg::status_e             status;
  logic [rddg_pkg::POS_W-1:0]    cycle_start;
  logic [rddg_pkg::POS_W-1:0]    cycle_length;

  modport source (output valid, digit, position, status, cycle_start, cycle_length,
                  input ready);
  modport sink   (input valid, digit, position, status, cycle_start, cycle_length,
                  output ready);
endinterface

// ===== rtl/rddg_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module rddg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/repeating_decimal_digit_generator_unit.sv =====
// repeating decimal digit generator: long division, one digit per request
// start or next request: 16 divide steps, then finish, which registers the result when the
// output register is free; error request: straight to finish; one request in flight at a
// time; the radix-2 divider makes one quotient bit a cycle; after reset a pass over all 1024
// entries clears the first-position table; every 63rd nonzero-divisor start is followed
// by the same pass when the table generation tag wraps; no request is taken meanwhile
module repeating_decimal_digit_generator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  rddg_req_if.sink          req_i,
  rddg_res_if.source        res_o
);

  // sequencer state
  rddg_pkg::state_e state_q, state_d;
  rddg_pkg::kind_e  kind_q, kind_d;

  // division context
  logic [rddg_pkg::DIV_W-1:0]   held_div_q, held_div_d;
  logic [rddg_pkg::DIV_W-1:0]   rem_q, rem_d;
  logic [rddg_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                         active_q, active_d;

  // shared radix-2 divider: quotient shifts in from the low end of quo_q
  logic [rddg_pkg::NUM_W-1:0]   quo_q, quo_d;
  logic [rddg_pkg::DIV_W-1:0]   prem_q, prem_d;
  logic [rddg_pkg::STEP_W-1:0]  step_q, step_d;
  logic [rddg_pkg::DIV_W:0]     trial;
  logic [rddg_pkg::DIV_W:0]     diff;
  logic                         trial_ge;
  logic [rddg_pkg::DVD_W-1:0]   rem_x10;

  // table generation tag: an entry counts only if its tag matches epoch_q, so a start
  // clears the table by moving to the next tag, or by a sweep once the tag is exhausted
  logic [rddg_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  logic                         clr_pend_q, clr_pend_d;
  logic [rddg_pkg::TBL_AW-1:0]  clr_cnt_q, clr_cnt_d;

  // first-position table port signals
  logic                         tbl_we, tbl_re;
  logic [rddg_pkg::TBL_AW-1:0]  tbl_waddr;
  rddg_pkg::tbl_entry_t         tbl_wdata, tbl_rdata;

  // output register, parts the result side from the request side
  logic                         res_vld_q, res_vld_d;
  rddg_pkg::res_t               res_q, res_d;

  // next-digit lookup
  logic [rddg_pkg::POS_W-1:0]   pos_next;
  logic                         tbl_hit;

  rddg_ram #(
    .WIDTH ($bits(rddg_pkg::tbl_entry_t)),
    .DEPTH (rddg_pkg::TBL_DEPTH)
  ) u_first_seen (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (rem_q),
    .rdata_o (tbl_rdata)
  );

  // ten times the remainder as shift and add
  assign rem_x10 = {1'b0, rem_q, 3'b000} + {3'b000, rem_q, 1'b0};

  // one restoring divide step
  assign trial    = {prem_q, quo_q[rddg_pkg::NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, held_div_q});
  assign diff     = trial - {1'b0, held_div_q};

  assign pos_next = pos_q + rddg_pkg::POS_W'(1);
  // the read issued at acceptance stays in the ram output register until finish
  assign tbl_hit  = (tbl_rdata.epoch == epoch_q);

  assign req_i.ready        = (state_q == rddg_pkg::S_IDLE);
  assign res_o.valid        = res_vld_q;
  assign res_o.digit        = res_q.digit;
  assign res_o.position     = res_q.position;
  assign res_o.status       = res_q.status;
  assign res_o.cycle_start  = res_q.cycle_start;
  assign res_o.cycle_length = res_q.cycle_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rddg_pkg::S_CLEAR;
      kind_q     <= rddg_pkg::KIND_ERROR;
      active_q   <= 1'b0;
      held_div_q <= '0;
      rem_q      <= '0;
      pos_q      <= '0;
      step_q     <= '0;
      epoch_q    <= rddg_pkg::EPOCH_FIRST;
      clr_pend_q <= 1'b0;
      clr_cnt_q  <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      active_q   <= active_d;
      held_div_q <= held_div_d;
      rem_q      <= rem_d;
      pos_q      <= pos_d;
      step_q     <= step_d;
      epoch_q    <= epoch_d;
      clr_pend_q <= clr_pend_d;
      clr_cnt_q  <= clr_cnt_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // divider operands and result payload
  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    prem_q <= prem_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    active_d   = active_q;
    held_div_d = held_div_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    quo_d      = quo_q;
    prem_d     = prem_q;
    step_d     = step_q;
    epoch_d    = epoch_q;
    clr_pend_d = clr_pend_q;
    clr_cnt_d  = clr_cnt_q;
    res_d      = res_q;
    res_vld_d  = res_vld_q && !res_o.ready;
    tbl_we     = 1'b0;
    tbl_re     = 1'b0;
    tbl_waddr  = rem_q;
    tbl_wdata  = '0;

    unique case (state_q)
      rddg_pkg::S_CLEAR: begin
        // sweep the table to tag zero, which no division ever uses
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + rddg_pkg::TBL_AW'(1);
        if (clr_cnt_q == '1) begin
          epoch_d = rddg_pkg::EPOCH_FIRST;
          state_d = rddg_pkg::S_IDLE;
        end
      end

      rddg_pkg::S_IDLE: begin
        if (req_i.valid) begin
          step_d = '0;
          prem_d = '0;
          if (req_i.func == rddg_pkg::FUNC_START) begin
            if (req_i.divisor == '0) begin
              kind_d   = rddg_pkg::KIND_ERROR;
              active_d = 1'b0;
              state_d  = rddg_pkg::S_FINISH;
            end else begin
              kind_d     = rddg_pkg::KIND_START;
              held_div_d = req_i.divisor;
              quo_d      = req_i.numerator;
              state_d    = rddg_pkg::S_DIV;
              // tag exhausted: clear the table once the integer part is out
              if (epoch_q == rddg_pkg::EPOCH_MAX) begin
                clr_pend_d = 1'b1;
              end else begin
                epoch_d = epoch_q + rddg_pkg::EPOCH_W'(1);
              end
            end
          end else if (!active_q) begin
            kind_d  = rddg_pkg::KIND_ERROR;
            state_d = rddg_pkg::S_FINISH;
          end else begin
            kind_d  = rddg_pkg::KIND_NEXT;
            tbl_re  = 1'b1;
            quo_d   = rddg_pkg::NUM_W'(rem_x10);
            state_d = rddg_pkg::S_DIV;
          end
        end
      end

      rddg_pkg::S_DIV: begin
        prem_d = trial_ge ? diff[rddg_pkg::DIV_W-1:0] : trial[rddg_pkg::DIV_W-1:0];
        quo_d  = {quo_q[rddg_pkg::NUM_W-2:0], trial_ge};
        step_d = step_q + rddg_pkg::STEP_W'(1);
        if (step_q == rddg_pkg::STEP_LAST) begin
          state_d = rddg_pkg::S_FINISH;
        end
      end

      rddg_pkg::S_FINISH: begin
        // wait for a free output register, then commit state and result together
        if (!res_vld_q || res_o.ready) begin
          res_vld_d = 1'b1;
          res_d     = '0;
          state_d   = clr_pend_q ? rddg_pkg::S_CLEAR : rddg_pkg::S_IDLE;
          clr_pend_d = 1'b0;
          case (kind_q)
            rddg_pkg::KIND_START: begin
              res_d.digit = quo_q;
              rem_d       = prem_q;
              pos_d       = '0;
              active_d    = (prem_q != '0);
              res_d.status = (prem_q == '0) ? rddg_pkg::STAT_EXACT : rddg_pkg::STAT_MORE;
            end
            rddg_pkg::KIND_NEXT: begin
              res_d.digit    = quo_q;
              res_d.position = pos_next;
              pos_d          = pos_next;
              if (tbl_hit) begin
                // dividend met before: the repetend runs from its first position
                res_d.status       = rddg_pkg::STAT_REPEAT;
                res_d.cycle_start  = tbl_rdata.pos;
                res_d.cycle_length = pos_next - tbl_rdata.pos;
                active_d           = 1'b0;
              end else begin
                tbl_we          = 1'b1;
                tbl_wdata.epoch = epoch_q;
                tbl_wdata.pos   = pos_next;
                rem_d           = prem_q;
                active_d        = (prem_q != '0);
                res_d.status    = (prem_q == '0) ? rddg_pkg::STAT_EXACT
                                                 : rddg_pkg::STAT_MORE;
              end
            end
            default: begin
              res_d.status = rddg_pkg::STAT_ERROR;
              active_d     = 1'b0;
            end
          endcase
        end
      end

      default: begin
        state_d = rddg_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rddg_checker.sv =====
// port-level checks of the repeating decimal digit generator, with its bind
// depends on rddg_pkg and the top level
module rddg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input logic [rddg_pkg::DIGIT_W-1:0] res_digit_i,
  input logic [rddg_pkg::POS_W-1:0]   res_position_i,
  input rddg_pkg::status_e            res_status_i,
  input logic [rddg_pkg::POS_W-1:0]   res_cycle_start_i,
  input logic [rddg_pkg::POS_W-1:0]   res_cycle_length_i
);

  // a stalled result holds still
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_digit_i)
      && $stable(res_position_i) && $stable(res_status_i)
      && $stable(res_cycle_start_i) && $stable(res_cycle_length_i))
    else $error("stalled result changed");

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // error results carry nothing but the status
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == rddg_pkg::STAT_ERROR |->
      res_digit_i == '0 && res_position_i == '0
      && res_cycle_start_i == '0 && res_cycle_length_i == '0)
    else $error("error result with non-zero fields");

  // a repetend starts after the point and is never empty
  a_repeat_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == rddg_pkg::STAT_REPEAT |->
      res_cycle_start_i != '0 && res_cycle_length_i != '0
      && res_position_i != '0)
    else $error("bad repetend span");

  // digits after the point are decimal
  a_decimal_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i != rddg_pkg::STAT_ERROR && res_position_i != '0 |->
      res_digit_i <= rddg_pkg::DIGIT_W'(9))
    else $error("fractional digit above nine");

endmodule

bind repeating_decimal_digit_generator_unit rddg_checker u_rddg_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_digit_i        (res_o.digit),
  .res_position_i     (res_o.position),
  .res_status_i       (res_o.status),
  .res_cycle_start_i  (res_o.cycle_start),
  .res_cycle_length_i (res_o.cycle_length)
);

// ===== verif/tb_repeating_decimal_digit_generator_unit.sv =====
// testbench for the repeating decimal digit generator: random and directed division requests
// checked against a long-division predictor; needs rddg_pkg, rddg_req_if, rddg_res_if and the unit
`timescale 1ns / 100ps

module tb_repeating_decimal_digit_generator_unit;
  import rddg_pkg::*;

  typedef struct {
    logic             func;
    logic [NUM_W-1:0] numerator;
    logic [DIV_W-1:0] divisor;
  } div_request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rddg_req_if req_bus();
  rddg_res_if res_bus();

  repeating_decimal_digit_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  always #4 clk_i = ~clk_i;

  div_request_t request_q[$];     // requests waiting to be offered
  res_t         digits_due_q[$];  // predicted results, oldest first
  int unsigned  mismatch_count = 0;
  bit           steady = 1'b0;    // no idling on either side once set
  int unsigned  send_idle = 0;
  int unsigned  recv_stall = 0;

  // predictor state: operands, running remainder and first positions per remainder
  logic [DIV_W-1:0] held_div = '0;
  logic [DIV_W-1:0] part_rem = '0;
  logic [POS_W-1:0] digit_pos = '0;
  bit               in_division = 1'b0;
  bit               seen_at_valid [TBL_DEPTH];
  logic [POS_W-1:0] seen_at_pos [TBL_DEPTH];

  // one long-division step for an accepted request, updating the predictor state
  function automatic res_t predict_digit(input logic func, input logic [NUM_W-1:0] num,
                                         input logic [DIV_W-1:0] div);
    res_t             r;
    logic [DVD_W-1:0] ten_rem;
    r = '0;
    r.status = STAT_MORE;
    if (func == FUNC_START) begin
      if (div == '0) begin
        // zero divisor: error, table and operands untouched
        in_division = 1'b0;
        r.status = STAT_ERROR;
      end else begin
        held_div = div;
        digit_pos = '0;
        foreach (seen_at_valid[i]) seen_at_valid[i] = 1'b0;
        r.digit = num / div;
        part_rem = num % div;
        in_division = (part_rem != '0);
        if (!in_division) r.status = STAT_EXACT;
      end
    end else if (!in_division) begin
      // next with nothing running
      r.status = STAT_ERROR;
    end else begin
      ten_rem = part_rem * 10;
      digit_pos = digit_pos + 1'b1;
      r.digit = ten_rem / held_div;
      r.position = digit_pos;
      if (seen_at_valid[part_rem]) begin
        // same dividend met before: report the repetend and stop
        in_division = 1'b0;
        r.status = STAT_REPEAT;
        r.cycle_start = seen_at_pos[part_rem];
        r.cycle_length = digit_pos - seen_at_pos[part_rem];
      end else begin
        seen_at_valid[part_rem] = 1'b1;
        seen_at_pos[part_rem] = digit_pos;
        part_rem = ten_rem % held_div;
        if (part_rem == '0) begin
          in_division = 1'b0;
          r.status = STAT_EXACT;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // request side: offer queued requests with random idle bursts, predict on acceptance
  always @(posedge clk_i) begin : drive_requests
    div_request_t nxt;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      send_idle <= 0;
    end else begin
      if (req_bus.valid && req_bus.ready)
        digits_due_q.push_back(predict_digit(req_bus.func, req_bus.numerator,
                                             req_bus.divisor));
      if (!req_bus.valid || req_bus.ready) begin
        if (send_idle != 0) begin
          send_idle <= send_idle - 1;
          req_bus.valid <= 1'b0;
        end else if (request_q.size() == 0) begin
          req_bus.valid <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
          // idle burst: valid drops now and stays low while send_idle counts down
          send_idle <= $urandom_range(0, 3);
          req_bus.valid <= 1'b0;
        end else begin
          nxt = request_q.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.func <= nxt.func;
          req_bus.numerator <= nxt.numerator;
          req_bus.divisor <= nxt.divisor;
        end
      end
    end
  end

  // result side: random stall bursts, compare each result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (digits_due_q.size() == 0) begin
          $error("result with no request outstanding: digit %0d position %0d status %0d",
                 res_bus.digit, res_bus.position, res_bus.status);
          mismatch_count++;
        end else begin
          want = digits_due_q.pop_front();
          check_field("digit", want.digit, res_bus.digit);
          check_field("position", want.position, res_bus.position);
          check_field("status", want.status, res_bus.status);
          check_field("cycle_start", want.cycle_start, res_bus.cycle_start);
          check_field("cycle_length", want.cycle_length, res_bus.cycle_length);
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        res_bus.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(0, 3);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic add_request(input logic func, input logic [NUM_W-1:0] num,
                             input logic [DIV_W-1:0] div);
    div_request_t r;
    r.func = func;
    r.numerator = num;
    r.divisor = div;
    request_q.push_back(r);
  endtask

  // mostly whole divisions (start then a run of nexts), some noise and zero divisors
  task automatic add_random(input int unsigned n_items);
    int unsigned      added;
    int unsigned      sel;
    int unsigned      run;
    logic [DIV_W-1:0] d;
    logic [NUM_W-1:0] n;
    added = 0;
    while (added < n_items) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        add_request(1'($urandom_range(0, 1)), NUM_W'($urandom), DIV_W'($urandom));
        added++;
      end else if (sel < 3) begin
        add_request(FUNC_START, NUM_W'($urandom), '0);
        added++;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 13) d = DIV_W'($urandom_range(2, 40));
        else if (sel < 17) d = DIV_W'($urandom_range(41, 1023));
        else if (sel < 18) d = DIV_W'(1023);
        else d = DIV_W'(1);
        n = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(0, 99)) : NUM_W'($urandom);
        // small divisors usually run on past the end of the expansion
        if (d <= 40 && $urandom_range(0, 1) == 1) run = d + 2;
        else run = $urandom_range(0, (d <= 40) ? d + 2 : 30);
        add_request(FUNC_START, n, d);
        repeat (run) add_request(FUNC_NEXT, NUM_W'($urandom), DIV_W'($urandom));
        added += run + 1;
      end
    end
  endtask

  // hold further requests back until every result so far has come
  task automatic wait_drained();
    while (request_q.size() != 0 || req_bus.valid || digits_due_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_START;
    req_bus.numerator = '0;
    req_bus.divisor = '0;
    res_bus.ready = 1'b0;
    foreach (seen_at_valid[i]) begin
      seen_at_valid[i] = 1'b0;
      seen_at_pos[i] = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // next straight after reset, with nothing running
    add_request(FUNC_NEXT, '1, '1);
    // zero divisor with the largest numerator
    add_request(FUNC_START, '1, '0);
    // exact at start with the largest quotient, then a next after the end
    add_request(FUNC_START, '1, DIV_W'(1));
    add_request(FUNC_NEXT, '0, '0);
    // one third: repetend of length one right after the point
    add_request(FUNC_START, NUM_W'(1), DIV_W'(3));
    repeat (2) add_request(FUNC_NEXT, '0, '0);
    // one eighth: exact end after three digits
    add_request(FUNC_START, NUM_W'(1), DIV_W'(8));
    repeat (3) add_request(FUNC_NEXT, '1, '1);
    // zero numerator
    add_request(FUNC_START, '0, DIV_W'(5));
    // largest divisor, then a next whose operands must be ignored
    add_request(FUNC_START, '1, '1);
    add_request(FUNC_NEXT, NUM_W'(16'h5a5a), DIV_W'(10'h2a5));
    // one sixth: repetend starting at position two
    add_request(FUNC_START, NUM_W'(1), DIV_W'(6));
    repeat (3) add_request(FUNC_NEXT, '0, '0);
    // zero divisor in the middle of a division cancels it
    add_request(FUNC_START, NUM_W'(2), DIV_W'(3));
    add_request(FUNC_START, NUM_W'(7), '0);
    add_request(FUNC_NEXT, '0, '0);
    wait_drained();

    add_random(700);
    wait_drained();
    add_random(650);
    wait_drained();

    // closing stretch at full rate
    steady = 1'b1;
    add_random(200);
    wait_drained();
    repeat (40) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
